/* src/mtbj_pkg.sv */
// shared types, codes and constants of the timer table with backoff and jitter
// no dependencies
package mtbj_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int DL_W   = 40;
  localparam int CUR_W  = 34;
  localparam int BASE_W = 16;
  localparam int ABS_W  = 15;
  localparam int PCT_W  = 8;
  localparam int EXP_W  = 4;
  localparam int MODE_W = 3;
  localparam int LFSR_W = 32;
  localparam int DIV_N_W = 32;
  localparam int DIV_D_W = 17;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_0001;
  localparam logic [DL_W-1:0]   DL_MAX    = 40'hFF_FFFF_FFFF;
  localparam logic [DL_W-1:0]   NOW_INIT  = 40'h00_0000_0001;
  localparam logic [DIV_D_W-1:0] PCT_DIV  = 17'd100;
  // ceil(2^32/100): (x * PCT_RECIP) >> 32 equals x/100 for every x below 2^30
  localparam logic [25:0]       PCT_RECIP = 26'd42949673;

  // mode bit positions
  localparam int MODE_ONE_SHOT = 0;
  localparam int MODE_EXPONENT = 1;
  localparam int MODE_AUTO_DEL = 2;

  typedef enum logic [2:0] {
    OP_TICK, OP_CREATE, OP_START, OP_STOP, OP_SET, OP_ADJUST, OP_DESTROY, OP_NONE
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SCAN, R_SHIFT, R_ABS, R_PCT, R_PMOD, R_MUL, R_PDIV, R_FIN,
    S_MIN, S_OUT, S_STAT
  } state_t;

  typedef struct packed {
    logic                    valid;
    logic [MODE_W-1:0]       mode;
    logic [BASE_W-1:0]       base;
    logic signed [CUR_W-1:0] cur;
    logic [EXP_W-1:0]        exp;
    logic [EXP_W-1:0]        exp_max;
    logic [ABS_W-1:0]        jabs;
    logic signed [PCT_W-1:0] plo;
    logic signed [PCT_W-1:0] phi;
    logic [DL_W-1:0]         dl;
  } entry_t;

  typedef struct packed {
    logic wr;
    logic fire_set;
    logic fire_clr;
  } cell_ctl_t;

endpackage

/* src/multi_timer_backoff_jitter.sv */
// top level of the timer table: sequencer, re-arm datapath, clock and lfsr
// depends on mtbj_pkg, mtbj_cell and mtbj_div
//
// A table of NUM_TIMERS timers against a seconds clock, one operation per input
// word (tick, create, start, stop, set, adjust, destroy). Each timer lives in a
// cell of a chain; the cells also pass a running minimum of their deadlines to
// the neighbor every cycle, so the earliest deadline is ready once the last
// change has rippled through every cell. A tick visits the cells in index order,
// one per cycle while no re-arm is under way; every periodic timer that fires
// is re-armed through one shared datapath: a bit-serial divider takes the
// absolute jitter modulo and the percent modulo (each only when that jitter is
// in use) and the divide by 100 is a reciprocal multiply. Fired words are held
// back until the minimum is known, then sent in index order followed by the
// status word. A new input word is taken only when the previous one is fully
// worked off; its status word may still sit in the output register.
module multi_timer_backoff_jitter #(
  parameter int NUM_TIMERS = mtbj_pkg::NUM_TIMERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       in_opcode,
  input  logic [2:0]                       in_timer_index,
  input  logic [mtbj_pkg::BASE_W-1:0]      in_interval_value,
  input  logic [mtbj_pkg::MODE_W-1:0]      in_mode_bits,
  input  logic [mtbj_pkg::ABS_W-1:0]       in_jitter_abs,
  input  logic signed [mtbj_pkg::PCT_W-1:0] in_jitter_low_pct,
  input  logic signed [mtbj_pkg::PCT_W-1:0] in_jitter_high_pct,
  input  logic [mtbj_pkg::EXP_W-1:0]       in_exponent_start,
  input  logic [mtbj_pkg::EXP_W-1:0]       in_exponent_limit,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_result_kind,
  output logic [2:0]                       out_fired_index,
  output logic [mtbj_pkg::DL_W-1:0]        out_earliest_deadline,
  output logic                             out_error_code,
  output logic                             out_last
);
  import mtbj_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int SUM_W = DL_W + 2;

  // galois lfsr, one step per draw
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] x);
    logic [LFSR_W-1:0] s;
    s = x >> 1;
    if (x[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

  // saturate a new deadline into 1 .. 2^40-1
  function automatic logic [DL_W-1:0] clamp_dl(input logic signed [SUM_W-1:0] v);
    logic [DL_W-1:0] r;
    if (v < SUM_W'(1)) begin
      r = NOW_INIT;
    end else if (v > $signed({2'b00, DL_MAX})) begin
      r = DL_MAX;
    end else begin
      r = v[DL_W-1:0];
    end
    return r;
  endfunction

  // sequencer and captured word
  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic [2:0]              idx_r, idx_nxt;
  logic [BASE_W-1:0]       ival_r, ival_nxt;
  logic [MODE_W-1:0]       mode_r, mode_nxt;
  logic [ABS_W-1:0]        jabs_r, jabs_nxt;
  logic signed [PCT_W-1:0] jlo_r, jlo_nxt;
  logic signed [PCT_W-1:0] jhi_r, jhi_nxt;
  logic [EXP_W-1:0]        es_r, es_nxt;
  logic [EXP_W-1:0]        el_r, el_nxt;
  logic                    err_r, err_nxt;

  // clock, random source, counters
  logic [DL_W-1:0]   now_r, now_nxt;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic [IW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  // re-arm datapath
  entry_t                  ent_r, ent_nxt;
  logic [IW-1:0]           sel_r, sel_nxt;
  logic                    ret_scan_r, ret_scan_nxt;
  logic [DL_W-1:0]         bdl_r, bdl_nxt;
  logic signed [CUR_W-1:0] iv_r, iv_nxt;
  logic signed [CUR_W-1:0] jit_r, jit_nxt;
  logic signed [24:0]      prod_r, prod_nxt;
  logic [18:0]             q_r, q_nxt;
  logic [DL_W-1:0]         min_r, min_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  logic            out_kind_r, out_kind_nxt;
  logic [2:0]      out_idx_r, out_idx_nxt;
  logic [DL_W-1:0] out_dl_r, out_dl_nxt;
  logic            out_err_r, out_err_nxt;
  logic            out_last_r, out_last_nxt;

  // cell chain wiring
  entry_t            ents [NUM_TIMERS];
  cell_ctl_t         ctl  [NUM_TIMERS];
  logic [DL_W-1:0]   mins [NUM_TIMERS+1];
  logic [NUM_TIMERS-1:0] fired_v;
  entry_t            wdata;
  logic [IW-1:0]     wsel;
  logic              wr_en;
  logic              fire_set;
  logic              fire_clr;

  // divider hookup
  logic               div_start;
  logic [DIV_N_W-1:0] div_dividend;
  logic [DIV_D_W-1:0] div_divisor;
  logic               div_done;
  logic [DIV_D_W-1:0] div_rem;

  assign mins[0] = '0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    always_comb begin
      ctl[i].wr       = wr_en && (wsel == IW'(i));
      ctl[i].fire_set = fire_set && (k_r == IW'(i));
      ctl[i].fire_clr = fire_clr;
    end
    mtbj_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl[i]),
      .wr_data (wdata),
      .min_in  (mins[i]),
      .ent     (ents[i]),
      .fired   (fired_v[i]),
      .min_out (mins[i+1])
    );
  end

  mtbj_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  // addressed entry
  logic [IW-1:0] t_sel;
  logic          idx_ok;
  entry_t        cur_e;
  assign t_sel  = IW'(idx_r);
  assign idx_ok = (int'(idx_r) < NUM_TIMERS);
  assign cur_e  = ents[t_sel];

  logic free;
  assign free = !out_valid_r || !out_stall;

  always_comb begin
    entry_t                  e;
    entry_t                  c;
    logic [30:0]             shv;
    logic signed [8:0]       range;
    logic signed [8:0]       pct;
    logic signed [25:0]      prod_w;
    logic [24:0]             prod_mag;
    logic [50:0]             recip_p;
    logic signed [CUR_W-1:0] term;
    logic signed [CUR_W-1:0] tot;
    logic signed [SUM_W-1:0] sum;
    logic                    due;
    logic                    advance;
    logic [LFSR_W-1:0]       drawn;

    e        = cur_e;
    c        = ents[k_r];
    shv      = '0;
    range    = $signed({ent_r.phi[PCT_W-1], ent_r.phi}) - $signed({ent_r.plo[PCT_W-1], ent_r.plo});
    pct      = $signed({ent_r.plo[PCT_W-1], ent_r.plo}) + $signed(div_rem[8:0]);
    prod_w   = $signed({10'd0, ent_r.base}) * 26'(pct);
    prod_mag = prod_r[24] ? 25'(-prod_r) : 25'(prod_r);
    // magnitude over 100 by reciprocal multiply, truncated toward zero
    recip_p  = 51'(prod_mag) * 51'(PCT_RECIP);
    term     = prod_r[24] ? -$signed({15'd0, q_r}) : $signed({15'd0, q_r});
    tot      = iv_r + jit_r;
    sum      = '0;
    due      = c.valid && (c.dl != '0) && (c.dl <= now_r);
    advance  = 1'b0;
    drawn    = lfsr_step(lfsr_r);

    state_nxt    = state_r;
    op_nxt       = op_r;
    idx_nxt      = idx_r;
    ival_nxt     = ival_r;
    mode_nxt     = mode_r;
    jabs_nxt     = jabs_r;
    jlo_nxt      = jlo_r;
    jhi_nxt      = jhi_r;
    es_nxt       = es_r;
    el_nxt       = el_r;
    err_nxt      = err_r;
    now_nxt      = now_r;
    lfsr_nxt     = lfsr_r;
    k_nxt        = k_r;
    cnt_nxt      = cnt_r;
    ent_nxt      = ent_r;
    sel_nxt      = sel_r;
    ret_scan_nxt = ret_scan_r;
    bdl_nxt      = bdl_r;
    iv_nxt       = iv_r;
    jit_nxt      = jit_r;
    prod_nxt     = prod_r;
    q_nxt        = q_r;
    min_nxt      = min_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_dl_nxt    = out_dl_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;

    wdata        = ent_r;
    wsel         = t_sel;
    wr_en        = 1'b0;
    fire_set     = 1'b0;
    fire_clr     = 1'b0;
    div_start    = 1'b0;
    div_dividend = drawn;
    div_divisor  = PCT_DIV;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = op_t'(in_opcode);
          idx_nxt   = in_timer_index;
          ival_nxt  = in_interval_value;
          mode_nxt  = in_mode_bits;
          jabs_nxt  = in_jitter_abs;
          jlo_nxt   = in_jitter_low_pct;
          jhi_nxt   = in_jitter_high_pct;
          es_nxt    = in_exponent_start;
          el_nxt    = in_exponent_limit;
          err_nxt   = 1'b0;
          fire_clr  = 1'b1;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        cnt_nxt   = '0;
        state_nxt = S_MIN;
        case (op_r)
          OP_TICK: begin
            if (now_r != DL_MAX) begin
              now_nxt = now_r + 1'b1;
            end
            k_nxt     = '0;
            state_nxt = S_SCAN;
          end
          OP_CREATE: begin
            if (!idx_ok) begin
              err_nxt = 1'b1;
            end else begin
              wdata.valid   = 1'b1;
              wdata.mode    = mode_r;
              wdata.base    = ival_r;
              wdata.cur     = '0;
              wdata.exp     = es_r;
              wdata.exp_max = el_r;
              wdata.jabs    = jabs_r;
              wdata.plo     = jlo_r;
              wdata.phi     = jhi_r;
              wdata.dl      = '0;
              wr_en         = 1'b1;
            end
          end
          OP_NONE: begin
          end
          default: begin
            if (!idx_ok || !cur_e.valid) begin
              err_nxt = 1'b1;
            end else begin
              case (op_r)
                OP_START, OP_SET: begin
                  if (op_r == OP_SET) begin
                    e.base = ival_r;
                  end
                  if (op_r == OP_SET && cur_e.dl == '0) begin
                    wdata = e;
                    wr_en = 1'b1;
                  end else if (e.base == '0 && e.jabs == '0) begin
                    // nothing to run on: timer goes off
                    e.dl  = '0;
                    wdata = e;
                    wr_en = 1'b1;
                  end else begin
                    ent_nxt      = e;
                    sel_nxt      = t_sel;
                    bdl_nxt      = now_r;
                    ret_scan_nxt = 1'b0;
                    state_nxt    = R_SHIFT;
                  end
                end
                OP_STOP: begin
                  e.dl  = '0;
                  wdata = e;
                  wr_en = 1'b1;
                end
                OP_ADJUST: begin
                  e.base = ival_r;
                  if (cur_e.dl != '0) begin
                    sum = $signed({2'b00, cur_e.dl}) + $signed({26'd0, ival_r})
                          - SUM_W'(cur_e.cur);
                    e.dl = clamp_dl(sum);
                  end
                  wdata = e;
                  wr_en = 1'b1;
                end
                default: begin
                  // destroy
                  wdata = '0;
                  wr_en = 1'b1;
                end
              endcase
            end
          end
        endcase
      end

      S_SCAN: begin
        wsel = k_r;
        if (due) begin
          fire_set = 1'b1;
          if (c.mode[MODE_AUTO_DEL]) begin
            wdata   = '0;
            wr_en   = 1'b1;
            advance = 1'b1;
          end else if (c.mode[MODE_ONE_SHOT]) begin
            wdata    = c;
            wdata.dl = '0;
            wr_en    = 1'b1;
            advance  = 1'b1;
          end else begin
            ent_nxt      = c;
            sel_nxt      = k_r;
            bdl_nxt      = c.dl;
            ret_scan_nxt = 1'b1;
            state_nxt    = R_SHIFT;
          end
        end else begin
          advance = 1'b1;
        end
      end

      R_SHIFT: begin
        e = ent_r;
        if (e.mode[MODE_EXPONENT]) begin
          shv    = 31'(e.base) << e.exp;
          iv_nxt = $signed({3'b000, shv});
          if (e.exp < e.exp_max) begin
            e.exp = e.exp + 1'b1;
          end
        end else begin
          iv_nxt = $signed({18'd0, e.base});
        end
        ent_nxt = e;
        jit_nxt = '0;
        if (e.jabs != '0) begin
          lfsr_nxt    = drawn;
          div_start   = 1'b1;
          div_divisor = {1'b0, e.jabs, 1'b1};
          state_nxt   = R_ABS;
        end else begin
          state_nxt = R_PCT;
        end
      end

      R_ABS: begin
        if (div_done) begin
          jit_nxt   = $signed({17'd0, div_rem}) - $signed({19'd0, ent_r.jabs});
          state_nxt = R_PCT;
        end
      end

      R_PCT: begin
        if (range > 9'sd0) begin
          lfsr_nxt    = drawn;
          div_start   = 1'b1;
          div_divisor = {8'd0, range[8:0]} + 1'b1;
          state_nxt   = R_PMOD;
        end else begin
          state_nxt = R_FIN;
        end
      end

      R_PMOD: begin
        if (div_done) begin
          prod_nxt  = prod_w[24:0];
          state_nxt = R_MUL;
        end
      end

      R_MUL: begin
        q_nxt     = recip_p[50:32];
        state_nxt = R_PDIV;
      end

      R_PDIV: begin
        jit_nxt   = jit_r + term;
        state_nxt = R_FIN;
      end

      R_FIN: begin
        e     = ent_r;
        e.cur = tot;
        sum   = $signed({2'b00, bdl_r}) + SUM_W'(tot);
        e.dl  = clamp_dl(sum);
        wdata = e;
        wsel  = sel_r;
        wr_en = 1'b1;
        if (ret_scan_r) begin
          advance = 1'b1;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_MIN;
        end
      end

      S_MIN: begin
        // wait for the minimum to ripple through every cell
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_TIMERS)) begin
          min_nxt   = mins[NUM_TIMERS];
          k_nxt     = '0;
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (fired_v[k_r]) begin
          if (free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = 1'b0;
            out_idx_nxt   = 3'(k_r);
            out_dl_nxt    = min_r;
            out_err_nxt   = 1'b0;
            out_last_nxt  = 1'b0;
            if (k_r == IW'(NUM_TIMERS - 1)) begin
              state_nxt = S_STAT;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
        end else if (k_r == IW'(NUM_TIMERS - 1)) begin
          state_nxt = S_STAT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      S_STAT: begin
        if (free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b1;
          out_idx_nxt   = idx_r;
          out_dl_nxt    = min_r;
          out_err_nxt   = err_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // next entry of the tick scan
    if (advance) begin
      if (k_r == IW'(NUM_TIMERS - 1)) begin
        cnt_nxt   = '0;
        state_nxt = S_MIN;
      end else begin
        k_nxt     = k_r + 1'b1;
        state_nxt = S_SCAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= NOW_INIT;
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      cnt_r       <= '0;
      ret_scan_r  <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      ret_scan_r  <= ret_scan_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    ival_r     <= ival_nxt;
    mode_r     <= mode_nxt;
    jabs_r     <= jabs_nxt;
    jlo_r      <= jlo_nxt;
    jhi_r      <= jhi_nxt;
    es_r       <= es_nxt;
    el_r       <= el_nxt;
    ent_r      <= ent_nxt;
    sel_r      <= sel_nxt;
    bdl_r      <= bdl_nxt;
    iv_r       <= iv_nxt;
    jit_r      <= jit_nxt;
    prod_r     <= prod_nxt;
    q_r        <= q_nxt;
    min_r      <= min_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_dl_r   <= out_dl_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall              = (state_r != S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_result_kind       = out_kind_r;
  assign out_fired_index       = out_idx_r;
  assign out_earliest_deadline = out_dl_r;
  assign out_error_code        = out_err_r;
  assign out_last              = out_last_r;

  // the random source never locks up at zero
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n) lfsr_r != '0)
    else $error("lfsr reached zero");

  // the seconds clock never wraps to zero
  a_now_nonzero: assert property (@(posedge clk) disable iff (!rst_n) now_r != '0)
    else $error("seconds clock wrapped");

  // an accepted word goes straight to execution
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_EXEC)
    else $error("accepted word not executed");

  // a fired word is never flagged as last, the status word always is
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == out_kind_r))
    else $error("last flag disagrees with word kind");

endmodule

/* src/mtbj_cell.sv */
// one timer entry of the chain: holds the entry, its fired flag and a stage of
// the running-minimum chain; depends on mtbj_pkg
module mtbj_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mtbj_pkg::cell_ctl_t         ctl,
  input  mtbj_pkg::entry_t            wr_data,
  input  logic [mtbj_pkg::DL_W-1:0]   min_in,
  output mtbj_pkg::entry_t            ent,
  output logic                        fired,
  output logic [mtbj_pkg::DL_W-1:0]   min_out
);
  import mtbj_pkg::*;

  entry_t          ent_r;
  logic            fired_r;
  logic [DL_W-1:0] min_r;
  logic [DL_W-1:0] min_nxt;
  logic [DL_W-1:0] own;

  // zero means no running deadline
  always_comb begin
    own = (ent_r.valid && ent_r.dl != '0) ? ent_r.dl : '0;
    if (min_in == '0) begin
      min_nxt = own;
    end else if (own == '0) begin
      min_nxt = min_in;
    end else begin
      min_nxt = (own < min_in) ? own : min_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r   <= '0;
      fired_r <= 1'b0;
      min_r   <= '0;
    end else begin
      if (ctl.wr) begin
        ent_r <= wr_data;
      end
      if (ctl.fire_clr) begin
        fired_r <= 1'b0;
      end else if (ctl.fire_set) begin
        fired_r <= 1'b1;
      end
      min_r <= min_nxt;
    end
  end

  assign ent     = ent_r;
  assign fired   = fired_r;
  assign min_out = min_r;

endmodule

/* src/mtbj_div.sv */
// shared restoring divider for the jitter modulo, one quotient bit per cycle
// depends on mtbj_pkg
module mtbj_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mtbj_pkg::DIV_N_W-1:0]   dividend,
  input  logic [mtbj_pkg::DIV_D_W-1:0]   divisor,
  output logic                           done,
  output logic [mtbj_pkg::DIV_D_W-1:0]   rem
);
  import mtbj_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W-1:0] dvs_r;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;
  logic [DIV_D_W-1:0] rem_step;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_N_W-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = (trial >= {1'b0, dvs_r});
    rem_step = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_N_W-2:0], ge};
      rem_r <= rem_step;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
